>>> src/sfiu_pkg.sv
// ----------------------------------------------------------------------------
// sfiu_pkg
// Shared types and constants of the stack frame and interrupt unit.
// ----------------------------------------------------------------------------
package sfiu_pkg;

   localparam int MemBytes = 65536;
   localparam int AddrW = $clog2(MemBytes);
   localparam int NumRegs = 14;

   localparam logic [3:0] ActRegRd  = 4'd0;
   localparam logic [3:0] ActRegWr  = 4'd1;
   localparam logic [3:0] ActMemRd  = 4'd2;
   localparam logic [3:0] ActMemWr  = 4'd3;
   localparam logic [3:0] ActPush   = 4'd4;
   localparam logic [3:0] ActPop    = 4'd5;
   localparam logic [3:0] ActSave   = 4'd6;
   localparam logic [3:0] ActRestore = 4'd7;
   localparam logic [3:0] ActIrq    = 4'd8;

   localparam logic [3:0] RegIp = 4'd0;
   localparam logic [3:0] RegR1 = 4'd2;
   localparam logic [3:0] RegR8 = 4'd9;
   localparam logic [3:0] RegSp = 4'd10;
   localparam logic [3:0] RegFp = 4'd11;
   localparam logic [3:0] RegIm = 4'd13;

   localparam logic [63:0] ImReset = 64'h0000_0000_ffff_ffff;
   localparam logic [63:0] SpReset = 64'h0000_0000_ffff_fffe;

   localparam logic [0:0] CsrVectorBase = 1'b0;

   // One memory beat moves one byte; a multi-byte access is a run of beats.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MEM_RD,    // byte reads for mem read, pop, restore pops, vector fetch
      ST_MEM_WR,    // byte writes for mem write and pushes
      ST_STEP,      // sequencing between words of a frame
      ST_DONE
   } state_type;

   // Datapath word operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,       // capture the item
      OP_REG_ACCESS,  // register read or write
      OP_LOAD_SETUP,  // address of a memory read
      OP_STORE_SETUP, // address and data of a memory write
      OP_PUSH_SETUP,  // push of work data at SP
      OP_POP_SETUP,   // SP += n, size -= n, read at SP
      OP_BYTE_RD,
      OP_BYTE_WR,
      OP_SAVE_WORD,   // push the next frame word
      OP_SAVE_END,
      OP_RST_BEGIN,   // SP = FP + 8
      OP_RST_WORD,    // commit the popped word
      OP_IRQ_CHECK,
      OP_IRQ_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [3:0] action;
      logic       bytes_done;
      logic       irq_unmasked;
      logic       in_handler;
      logic [3:0] word_idx;
      logic       rsp_busy;
   } stat_type;

endpackage

>>> src/stack_frame_interrupt_unit.sv
// The unit takes one item at a time: req_ready is high only while idle, and the
// next item waits until the result of the last one has been loaded for output.
// A synchronous reset restores the register file, frame size and handler
// flag at once; memory needs no clearing and reads undefined until written.
// ----------------------------------------------------------------------------
// stack_frame_interrupt_unit
// Register file and downward stack of a small CPU with frame and interrupt
// sequencing over byte memory.
// ----------------------------------------------------------------------------
module stack_frame_interrupt_unit import sfiu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [3:0]  req_reg_index,
   input  logic [15:0] req_mem_address,
   input  logic [1:0]  req_size_code,
   input  logic [63:0] req_data_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_value,
   output logic        rsp_interrupt_taken,
   output logic        rsp_in_handler,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cmd_type    cmd;
   stat_type   stat;
   logic [15:0] vbase_ff;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vbase_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == CsrVectorBase) begin
         vbase_ff <= pwdata[15:0];
      end
   end
   assign prdata = (paddr[2] == CsrVectorBase) ? {16'd0, vbase_ff} : 32'd0;

   sfiu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfiu_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_action),
      .req_reg_index       (req_reg_index),
      .req_mem_address     (req_mem_address),
      .req_size_code       (req_size_code),
      .req_data_value      (req_data_value),
      .vector_base         (vbase_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_value      (rsp_read_value),
      .rsp_interrupt_taken (rsp_interrupt_taken),
      .rsp_in_handler      (rsp_in_handler)
   );
endmodule

>>> src/sfiu_ram.sv
// ----------------------------------------------------------------------------
// sfiu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sfiu_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

>>> src/sfiu_ctrl.sv
// ----------------------------------------------------------------------------
// sfiu_ctrl
// Sequencer: walks one item through its byte beats and frame words.
// ----------------------------------------------------------------------------
module sfiu_ctrl import sfiu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.action)
               ActMemRd, ActPop: state_in = ST_MEM_RD;
               ActMemWr, ActPush: state_in = ST_MEM_WR;
               ActSave: state_in = ST_STEP;
               ActRestore: state_in = ST_MEM_RD;
               ActIrq: begin
                  if (stat.irq_unmasked) begin
                     state_in = ST_MEM_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MEM_RD: begin
            if (stat.bytes_done) begin
               if (stat.action == ActRestore) begin
                  state_in = (stat.word_idx == 4'd10) ? ST_DONE : ST_STEP;
               end else if (stat.action == ActIrq) begin
                  state_in = stat.in_handler ? ST_DONE : ST_STEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MEM_WR: begin
            if (stat.bytes_done) begin
               if (stat.action == ActSave || stat.action == ActIrq) begin
                  state_in = (stat.word_idx == 4'd9) ? ST_DONE : ST_STEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_STEP: begin
            state_in = (stat.action == ActRestore) ? ST_MEM_RD : ST_MEM_WR;
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{op: OP_NONE, rsp_load: 1'b0};
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.op = OP_LATCH;
         end
         ST_DECODE: begin
            case (stat.action)
               ActRegRd, ActRegWr: cmd.op = OP_REG_ACCESS;
               ActMemRd: cmd.op = OP_LOAD_SETUP;
               ActMemWr: cmd.op = OP_STORE_SETUP;
               ActPush: cmd.op = OP_PUSH_SETUP;
               ActPop: cmd.op = OP_POP_SETUP;
               ActRestore: cmd.op = OP_RST_BEGIN;
               ActIrq: cmd.op = OP_IRQ_CHECK;
               default: cmd.op = OP_NONE;
            endcase
         end
         ST_MEM_RD: begin
            cmd.op = OP_BYTE_RD;
            if (stat.bytes_done) begin
               if (stat.action == ActRestore) begin
                  cmd.op = OP_RST_WORD;
               end else if (stat.action == ActIrq) begin
                  cmd.op = OP_IRQ_END;
               end
            end
         end
         ST_MEM_WR: begin
            cmd.op = OP_BYTE_WR;
            if (stat.bytes_done && stat.word_idx == 4'd9) begin
               cmd.op = OP_SAVE_END;
            end
         end
         ST_STEP: begin
            cmd.op = (stat.action == ActRestore) ? OP_POP_SETUP : OP_SAVE_WORD;
         end
         ST_DONE: begin
            cmd.rsp_load = !stat.rsp_busy;
         end
         default: cmd.op = OP_NONE;
      endcase
   end
endmodule

>>> src/sfiu_dp.sv
// ----------------------------------------------------------------------------
// sfiu_dp
// Datapath: register file, stack pointer arithmetic, byte memory port and
// the result register.
// ----------------------------------------------------------------------------
module sfiu_dp import sfiu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [3:0]  req_action,
   input  logic [3:0]  req_reg_index,
   input  logic [15:0] req_mem_address,
   input  logic [1:0]  req_size_code,
   input  logic [63:0] req_data_value,
   input  logic [15:0] vector_base,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_value,
   output logic        rsp_interrupt_taken,
   output logic        rsp_in_handler
);
   logic [63:0] regs_ff [NumRegs];
   logic [63:0] regs_in [NumRegs];
   logic [63:0] fsize_ff, fsize_in;
   logic        hflag_ff, hflag_in;

   logic [3:0]  act_ff;
   logic [3:0]  ridx_ff;
   logic [15:0] maddr_ff;
   logic [1:0]  size_ff;
   logic [63:0] data_ff;

   // Byte engine: address, byte count, shift data.
   logic [63:0] addr_ff, addr_in;
   logic [3:0]  cnt_ff, cnt_in;       // bytes left to issue
   logic [3:0]  got_ff, got_in;       // bytes returned
   logic [3:0]  len_ff, len_in;
   logic [63:0] wdat_ff, wdat_in;
   logic [63:0] rdat_ff, rdat_in;
   logic        rpend_ff, rpend_in;   // a read beat is in flight
   logic [3:0]  widx_ff, widx_in;
   logic [63:0] sfs_ff, sfs_in;       // saved frame size for restore
   logic [63:0] fpa_ff, fpa_in;       // old FP on restore, handler address on interrupt
   logic [63:0] rd_ff, rd_in;
   logic        taken_ff, taken_in;

   logic [63:0] rspv_ff;
   logic        rspt_ff, rsph_ff, rspvld_ff;

   logic        ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [7:0]  ram_q;
   logic [3:0]  nbytes;
   logic [63:0] nb64;
   logic [63:0] sp;
   logic [63:0] frame_word;
   logic [63:0] vaddr;

   assign nbytes = 4'd1 << size_ff;
   assign nb64 = {60'd0, nbytes};
   assign sp = regs_ff[RegSp];
   assign vaddr = {48'd0, vector_base} + {52'd0, data_ff[5:0], 3'd0};

   // Word pushed at frame step k: 0..7 R1..R8, 8 IP, 9 size+8; irq adds a zero first.
   always_comb begin
      if (widx_ff <= 4'd7) begin
         frame_word = regs_ff[RegR1 + widx_ff];
      end else if (widx_ff == 4'd8) begin
         frame_word = regs_ff[RegIp];
      end else begin
         frame_word = fsize_ff + 64'd8;
      end
   end

   assign ram_we = (cmd.op == OP_BYTE_WR) && (cnt_ff != 4'd0);
   assign ram_addr = addr_ff[AddrW-1:0];

   sfiu_ram #(.Width(8), .Depth(MemBytes)) u_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (wdat_ff[7:0]),
      .rd_data (ram_q)
   );

   // Writes clear both byte counters, so one test covers reads and writes.
   always_comb begin
      stat.action = act_ff;
      stat.in_handler = hflag_ff;
      stat.irq_unmasked = regs_ff[RegIm][data_ff[5:0]];
      stat.word_idx = widx_ff;
      stat.rsp_busy = rspvld_ff;
      stat.bytes_done = (got_ff == len_ff) && !rpend_ff && (cnt_ff == 4'd0);
   end

   always_comb begin
      for (int i = 0; i < NumRegs; i++) begin
         regs_in[i] = regs_ff[i];
      end
      fsize_in = fsize_ff;
      hflag_in = hflag_ff;
      addr_in = addr_ff;
      cnt_in = cnt_ff;
      got_in = got_ff;
      len_in = len_ff;
      wdat_in = wdat_ff;
      rdat_in = rdat_ff;
      rpend_in = 1'b0;
      widx_in = widx_ff;
      sfs_in = sfs_ff;
      fpa_in = fpa_ff;
      rd_in = rd_ff;
      taken_in = taken_ff;

      // Collect the byte that returns from a previous read beat.
      if (rpend_ff) begin
         rdat_in = rdat_ff | ({56'd0, ram_q} << {got_ff[2:0], 3'd0});
         got_in = got_ff + 4'd1;
      end

      case (cmd.op)
         OP_LATCH: begin
            rd_in = '0;
            taken_in = 1'b0;
            widx_in = 4'd0;
         end
         OP_REG_ACCESS: begin
            if (ridx_ff < 4'(NumRegs)) begin
               if (act_ff == ActRegRd) begin
                  rd_in = regs_ff[ridx_ff];
               end else begin
                  regs_in[ridx_ff] = data_ff;
               end
            end
         end
         OP_LOAD_SETUP: begin
            addr_in = {48'd0, maddr_ff};
            cnt_in = nbytes; len_in = nbytes; got_in = '0; rdat_in = '0;
         end
         OP_STORE_SETUP: begin
            addr_in = {48'd0, maddr_ff};
            cnt_in = nbytes; wdat_in = data_ff;
            got_in = '0; len_in = '0;
         end
         OP_PUSH_SETUP: begin
            addr_in = sp; cnt_in = nbytes; wdat_in = data_ff;
            got_in = '0; len_in = '0;
            regs_in[RegSp] = sp - nb64;
            fsize_in = fsize_ff + nb64;
         end
         OP_POP_SETUP: begin
            if (act_ff == ActRestore) begin
               addr_in = sp + 64'd8;
               regs_in[RegSp] = sp + 64'd8;
               fsize_in = fsize_ff - 64'd8;
               cnt_in = 4'd8; len_in = 4'd8;
            end else begin
               addr_in = sp + nb64;
               regs_in[RegSp] = sp + nb64;
               fsize_in = fsize_ff - nb64;
               cnt_in = nbytes; len_in = nbytes;
            end
            got_in = '0; rdat_in = '0;
         end
         OP_RST_BEGIN: begin
            fpa_in = regs_ff[RegFp];
            regs_in[RegSp] = regs_ff[RegFp] + 64'd8;
            addr_in = regs_ff[RegFp] + 64'd8;
            fsize_in = fsize_ff - 64'd8;
            cnt_in = 4'd8; len_in = 4'd8; got_in = '0; rdat_in = '0;
            widx_in = 4'd0;
         end
         OP_IRQ_CHECK: begin
            addr_in = vaddr;
            cnt_in = 4'd8; len_in = 4'd8; got_in = '0; rdat_in = '0;
         end
         OP_BYTE_RD: begin
            if (cnt_ff != 4'd0) begin
               rpend_in = 1'b1;
               cnt_in = cnt_ff - 4'd1;
               addr_in = addr_ff + 64'd1;
            end
         end
         OP_BYTE_WR: begin
            if (cnt_ff != 4'd0) begin
               cnt_in = cnt_ff - 4'd1;
               addr_in = addr_ff + 64'd1;
               wdat_in = wdat_ff >> 8;
            end else if (act_ff == ActSave || act_ff == ActIrq) begin
               widx_in = widx_ff + 4'd1;
            end else begin
               rd_in = '0;
            end
         end
         OP_SAVE_WORD: begin
            // The interrupt path pushes a zero argument count before the frame.
            if (act_ff == ActIrq && widx_ff == 4'd15) begin
               wdat_in = '0;
            end else begin
               wdat_in = frame_word;
            end
            addr_in = sp; cnt_in = 4'd8;
            got_in = '0; len_in = '0;
            regs_in[RegSp] = sp - 64'd8;
            fsize_in = fsize_ff + 64'd8;
         end
         OP_SAVE_END: begin
            regs_in[RegFp] = sp;
            fsize_in = '0;
            if (act_ff == ActIrq) begin
               regs_in[RegIp] = fpa_ff;
            end
         end
         OP_RST_WORD: begin
            case (widx_ff)
               4'd0: begin
                  fsize_in = rdat_ff;
                  sfs_in = rdat_ff;
               end
               4'd1: regs_in[RegIp] = rdat_ff;
               4'd10: begin
                  regs_in[RegSp] = sp + {rdat_ff[60:0], 3'd0};
                  fsize_in = fsize_ff - {rdat_ff[60:0], 3'd0};
                  regs_in[RegFp] = fpa_ff + sfs_ff;
               end
               default: regs_in[RegR8 - (widx_ff - 4'd2)] = rdat_ff;
            endcase
            widx_in = widx_ff + 4'd1;
         end
         OP_IRQ_END: begin
            // Outside a handler the old IP is saved first and the jump waits.
            if (hflag_ff) begin
               regs_in[RegIp] = rdat_ff;
            end else begin
               fpa_in = rdat_ff;
            end
            hflag_in = 1'b1;
            taken_in = 1'b1;
            widx_in = 4'd15;
         end
         default: ;
      endcase
      if (act_ff == ActMemRd || act_ff == ActPop) begin
         if (cmd.op == OP_BYTE_RD && stat.bytes_done) begin
            rd_in = rdat_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) begin
         act_ff <= req_action;
         ridx_ff <= req_reg_index;
         maddr_ff <= req_mem_address;
         size_ff <= req_size_code;
         data_ff <= req_data_value;
      end
      addr_ff <= addr_in;
      got_ff <= got_in;
      len_ff <= len_in;
      wdat_ff <= wdat_in;
      rdat_ff <= rdat_in;
      sfs_ff <= sfs_in;
      fpa_ff <= fpa_in;
      rd_ff <= rd_in;
      rspv_ff <= cmd.rsp_load ? rd_ff : rspv_ff;
      rspt_ff <= cmd.rsp_load ? taken_ff : rspt_ff;
      rsph_ff <= cmd.rsp_load ? hflag_ff : rsph_ff;
      for (int i = 0; i < NumRegs; i++) begin
         regs_ff[i] <= regs_in[i];
      end
      fsize_ff <= fsize_in;
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[RegIm] <= ImReset;
         regs_ff[RegSp] <= SpReset;
         regs_ff[RegFp] <= SpReset;
         fsize_ff <= '0;
         hflag_ff <= 1'b0;
         cnt_ff <= '0;
         rpend_ff <= 1'b0;
         widx_ff <= '0;
         taken_ff <= 1'b0;
         rspvld_ff <= 1'b0;
      end else begin
         hflag_ff <= hflag_in;
         cnt_ff <= cnt_in;
         rpend_ff <= rpend_in;
         widx_ff <= widx_in;
         taken_ff <= taken_in;
         if (cmd.rsp_load) begin
            rspvld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rspvld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rspvld_ff;
   assign rsp_read_value = rspv_ff;
   assign rsp_interrupt_taken = rspt_ff;
   assign rsp_in_handler = rsph_ff;
endmodule

>>> src/sfiu_checker.sv
// ----------------------------------------------------------------------------
// sfiu_checker
// Port-level checks of the stack frame and interrupt unit.
// ----------------------------------------------------------------------------
module sfiu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_read_value,
   input logic        rsp_interrupt_taken,
   input logic        rsp_in_handler
);
   // The handler flag never drops once a beat has shown it set.
   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_handler) |=> !(rsp_valid && !rsp_in_handler))
      else $error("handler flag cleared");
   // A taken interrupt always reports being in a handler.
   a_taken_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_interrupt_taken) |-> rsp_in_handler)
      else $error("taken without handler flag");
   // Accepting an item drops req_ready, so no second item is taken early.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken early");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value)))
      else $error("result dropped");
endmodule

bind stack_frame_interrupt_unit sfiu_checker u_sfiu_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_read_value      (rsp_read_value),
   .rsp_interrupt_taken (rsp_interrupt_taken),
   .rsp_in_handler      (rsp_in_handler)
);

>>> test/tb_stack_frame_interrupt_unit.sv
// ----------------------------------------------------------------------------
// tb_stack_frame_interrupt_unit
// Drives register, memory, stack, frame and interrupt beats into the unit.
// A scoreboard keeps its own register file, byte memory, frame size and
// handler flag, predicts every result and compares it field by field.
// The vector base is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_stack_frame_interrupt_unit;
   import sfiu_pkg::*;

   typedef struct {
      logic [3:0]  action;
      logic [3:0]  reg_index;
      logic [15:0] mem_address;
      logic [1:0]  size_code;
      logic [63:0] data_value;
   } unit_item_t;

   typedef struct {
      logic [63:0] read_value;
      logic        interrupt_taken;
      logic        in_handler;
   } unit_result_t;

   class frame_unit_scoreboard;
      logic [63:0]  regs [NumRegs];
      logic [7:0]   mem [MemBytes];
      bit           known [MemBytes];
      logic [63:0]  frame_bytes;
      bit           handler;
      logic [15:0]  vector_base;
      unit_result_t expected [$];
      int           errors;

      function void clear();
         foreach (regs[i]) regs[i] = '0;
         foreach (known[i]) known[i] = 0;
         regs[RegIm] = ImReset;
         regs[RegSp] = SpReset;
         regs[RegFp] = SpReset;
         frame_bytes = '0;
         handler = 0;
         vector_base = '0;
         errors = 0;
      endfunction

      function logic [63:0] load(logic [63:0] a, int n);
         logic [63:0] v;
         logic [63:0] p;
         v = '0;
         for (int i = 0; i < n; i++) begin
            p = a + i;
            v |= 64'(mem[p[15:0]]) << (8 * i);
         end
         return v;
      endfunction

      function void store(logic [63:0] a, int n, logic [63:0] v);
         logic [63:0] p;
         for (int i = 0; i < n; i++) begin
            p = a + i;
            mem[p[15:0]] = v[8*i +: 8];
            known[p[15:0]] = 1;
         end
      endfunction

      function bit readable(logic [63:0] a, int n);
         logic [63:0] p;
         for (int i = 0; i < n; i++) begin
            p = a + i;
            if (!known[p[15:0]]) return 0;
         end
         return 1;
      endfunction

      function void push(logic [63:0] v, int n);
         store(regs[RegSp], n, v);
         regs[RegSp] -= n;
         frame_bytes += n;
      endfunction

      function logic [63:0] pop(int n);
         regs[RegSp] += n;
         frame_bytes -= n;
         return load(regs[RegSp], n);
      endfunction

      function void save_frame();
         for (int r = RegR1; r <= RegR8; r++) push(regs[r], 8);
         push(regs[RegIp], 8);
         push(frame_bytes + 8, 8);
         regs[RegFp] = regs[RegSp];
         frame_bytes = '0;
      endfunction

      function void restore_frame();
         logic [63:0] old_fp;
         logic [63:0] saved_size;
         logic [63:0] arg_count;
         old_fp = regs[RegFp];
         regs[RegSp] = old_fp;
         frame_bytes = pop(8);
         saved_size = frame_bytes;
         regs[RegIp] = pop(8);
         for (int r = RegR8; r >= RegR1; r--) regs[r] = pop(8);
         arg_count = pop(8);
         regs[RegSp] += arg_count * 8;
         frame_bytes -= arg_count * 8;
         regs[RegFp] = old_fp + saved_size;
      endfunction

      function void note_item(unit_item_t it);
         unit_result_t res;
         int n;
         logic [5:0] line;
         logic [63:0] target;
         n = 1 << it.size_code;
         res.read_value = '0;
         res.interrupt_taken = 0;
         case (it.action)
            ActRegRd: if (it.reg_index < NumRegs) res.read_value = regs[it.reg_index];
            ActRegWr: if (it.reg_index < NumRegs) regs[it.reg_index] = it.data_value;
            ActMemRd: res.read_value = load(64'(it.mem_address), n);
            ActMemWr: store(64'(it.mem_address), n, it.data_value);
            ActPush: push(it.data_value, n);
            ActPop: res.read_value = pop(n);
            ActSave: save_frame();
            ActRestore: restore_frame();
            ActIrq: begin
               line = it.data_value[5:0];
               if (regs[RegIm][line]) begin
                  target = load(64'(vector_base) + 64'(line) * 8, 8);
                  if (!handler) begin
                     push(64'd0, 8);
                     save_frame();
                  end
                  handler = 1;
                  regs[RegIp] = target;
                  res.interrupt_taken = 1;
               end
            end
            default: ;
         endcase
         res.in_handler = handler;
         expected.push_back(res);
      endfunction

      function void check_result(unit_result_t got);
         unit_result_t exp;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: read_value %h", got.read_value);
            return;
         end
         exp = expected.pop_front();
         if (got.read_value !== exp.read_value || got.interrupt_taken !== exp.interrupt_taken
             || got.in_handler !== exp.in_handler) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                        exp.read_value, exp.interrupt_taken, exp.in_handler,
                        got.read_value, got.interrupt_taken, got.in_handler);
         end
      endfunction
   endclass

   localparam int CycleLimit = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [3:0]  req_action = '0;
   logic [3:0]  req_reg_index = '0;
   logic [15:0] req_mem_address = '0;
   logic [1:0]  req_size_code = '0;
   logic [63:0] req_data_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_read_value;
   logic        rsp_interrupt_taken;
   logic        rsp_in_handler;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   frame_unit_scoreboard sb = new();
   unit_item_t plan [$];
   logic [15:0] written_addr [$];
   int cycles = 0;
   int rx_run = 0;
   bit rx_stalls = 1;
   bit tx_gaps = 1;
   int burst_left = 0;

   stack_frame_interrupt_unit dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      unit_result_t got;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.read_value = rsp_read_value;
         got.interrupt_taken = rsp_interrupt_taken;
         got.in_handler = rsp_in_handler;
         sb.check_result(got);
      end
      // The receiver goes through runs of ready and stall of random length; stalls are off while rx_stalls is clear.
      if (rx_run <= 1) begin
         if (rx_stalls && $urandom_range(0, 9) < 4) begin
            rsp_ready <= 0;
            rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         end else begin
            rsp_ready <= 1;
            rx_run = $urandom_range(1, 12);
         end
      end else
         rx_run--;
   end

   function automatic unit_item_t mk(logic [3:0] a, logic [3:0] r, logic [15:0] adr,
                                     logic [1:0] sz, logic [63:0] d);
      unit_item_t it;
      it.action = a;
      it.reg_index = r;
      it.mem_address = adr;
      it.size_code = sz;
      it.data_value = d;
      return it;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(unit_item_t it);
      req_action <= it.action;
      req_reg_index <= it.reg_index;
      req_mem_address <= it.mem_address;
      req_size_code <= it.size_code;
      req_data_value <= it.data_value;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
      if (it.action == ActMemWr) written_addr.push_back(it.mem_address);
      if (written_addr.size() > 32) void'(written_addr.pop_front());
      if (burst_left > 0)
         burst_left--;
      else begin
         burst_left = $urandom_range(0, 15);
         if (tx_gaps && $urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic csr_write(logic [31:0] value);
      @(posedge clock);
      psel <= 1;
      pwrite <= 1;
      paddr <= 3'(CsrVectorBase);
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.vector_base = value[15:0];
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.expected.size() != 0) @(posedge clock);
      // A masked or unused beat still keeps the unit busy a little while.
      repeat (120) @(posedge clock);
   endtask

   // Saving a frame needs an argument count word just above the saved R1.
   task automatic plan_frame_save();
      plan.push_back(mk(ActPush, '0, '0, 2'd3,
                        ($urandom_range(0, 19) == 0) ? rand64() : 64'($urandom_range(0, 2))));
      plan.push_back(mk(ActSave, 4'($urandom), 16'($urandom), 2'($urandom), rand64()));
   endtask

   task automatic plan_random();
      int pick;
      int n;
      logic [1:0] sz;
      logic [15:0] adr;
      logic [5:0] line;
      logic [63:0] vec;
      pick = $urandom_range(0, 99);
      sz = 2'($urandom);
      n = 1 << sz;
      adr = 16'($urandom);
      if (pick < 8)
         plan.push_back(mk(ActRegRd, 4'($urandom), adr, sz, rand64()));
      else if (pick < 14)
         plan.push_back(mk(ActRegWr, 4'($urandom), adr, sz, rand64()));
      else if (pick < 26)
         plan.push_back(mk(ActMemWr, 4'($urandom), adr, sz, rand64()));
      else if (pick < 36) begin
         if (written_addr.size() > 0 && $urandom_range(0, 3) != 0)
            adr = written_addr[$urandom_range(0, written_addr.size() - 1)];
         if (sb.readable(64'(adr), n))
            plan.push_back(mk(ActMemRd, 4'($urandom), adr, sz, rand64()));
         else
            plan.push_back(mk(ActMemWr, 4'($urandom), adr, 2'd3, rand64()));
      end else if (pick < 52)
         plan.push_back(mk(ActPush, 4'($urandom), adr, sz, rand64()));
      else if (pick < 64) begin
         if (sb.readable(sb.regs[RegSp] + n, n))
            plan.push_back(mk(ActPop, 4'($urandom), adr, sz, rand64()));
         else
            plan.push_back(mk(ActMemWr, '0, 16'(sb.regs[RegSp] + 1), 2'd3, rand64()));
      end else if (pick < 72)
         plan_frame_save();
      else if (pick < 82) begin
         if (sb.readable(sb.regs[RegFp] + 8, 88))
            plan.push_back(mk(ActRestore, 4'($urandom), adr, sz, rand64()));
         else
            plan_frame_save();
      end else if (pick < 97) begin
         vec = rand64();
         line = vec[5:0];
         adr = sb.vector_base + 16'(line) * 16'd8;
         if (sb.regs[RegIm][line] && !sb.readable(64'(adr), 8))
            plan.push_back(mk(ActMemWr, '0, adr, 2'd3, rand64()));
         else
            plan.push_back(mk(ActIrq, 4'($urandom), 16'($urandom), sz, vec));
      end else
         plan.push_back(mk(4'($urandom_range(9, 15)), 4'($urandom), adr, sz, rand64()));
   endtask

   task automatic plan_directed();
      plan.push_back(mk(ActRegRd, RegIp, '0, '0, '0));
      plan.push_back(mk(ActRegRd, RegSp, '0, '0, '0));
      plan.push_back(mk(ActRegRd, RegIm, '0, '0, '0));
      plan.push_back(mk(ActRegRd, 4'd15, '0, '0, '0));
      plan.push_back(mk(ActRegWr, 4'd14, '0, '0, '1));
      plan.push_back(mk(ActRegWr, RegR1, '1, 2'd3, 64'h8000_0000_0000_0001));
      // An eight-byte access at the top of memory wraps to address zero.
      plan.push_back(mk(ActMemWr, '0, 16'hfffc, 2'd3, '1));
      plan.push_back(mk(ActMemRd, '0, 16'hfffc, 2'd3, '0));
      plan.push_back(mk(ActMemWr, '0, 16'h0028, 2'd3, 64'h0123_4567_89ab_cdef));
      plan.push_back(mk(ActMemRd, '0, 16'h0029, 2'd1, '0));
      plan.push_back(mk(ActPush, '0, '0, 2'd0, 64'h5a));
      plan.push_back(mk(ActPush, '0, '0, 2'd1, 64'hbeef));
      plan.push_back(mk(ActPush, '0, '0, 2'd2, 64'hdead_c0de));
      plan.push_back(mk(ActPop, '0, '0, 2'd2, '0));
      plan.push_back(mk(ActPop, '0, '0, 2'd1, '0));
      plan.push_back(mk(ActPop, '0, '0, 2'd0, '0));
      plan.push_back(mk(ActPush, '0, '0, 2'd3, 64'h1111));
      plan.push_back(mk(ActPush, '0, '0, 2'd3, 64'd1));
      plan.push_back(mk(ActSave, '0, '0, '0, '0));
      plan.push_back(mk(ActRestore, '0, '0, '0, '0));
      plan.push_back(mk(ActIrq, '0, '0, '0, 64'd63));
      plan.push_back(mk(ActIrq, '0, '0, '0, 64'hffff_ffff_ffff_ffc5));
      plan.push_back(mk(ActIrq, '0, '0, '0, 64'd5));
      plan.push_back(mk(ActRestore, '0, '0, '0, '0));
      plan.push_back(mk(ActRegWr, RegIm, '0, '0, '0));
      plan.push_back(mk(ActIrq, '0, '0, '0, 64'd5));
      plan.push_back(mk(ActRegWr, RegIm, '0, '0, '1));
      plan.push_back(mk(4'd9, '0, '0, '0, '1));
      plan.push_back(mk(4'd15, '1, '1, '1, '1));
   endtask

   initial begin
      logic [15:0] bases [4];
      sb.clear();
      bases[0] = 16'h0000;
      bases[1] = 16'hffff;
      bases[2] = 16'($urandom);
      bases[3] = 16'hfe00;
      repeat (10) @(posedge clock);
      reset <= 0;
      for (int ph = 0; ph < 4; ph++) begin
         csr_write({16'($urandom), bases[ph]});
         rx_stalls = (ph != 2);
         tx_gaps = (ph != 2);
         if (ph == 0) plan_directed();
         for (int k = 0; k < 212; k++) begin
            if (plan.size() == 0) plan_random();
            send_item(plan.pop_front());
            // Once in a while the sender holds off until every result is back.
            if ($urandom_range(0, 99) == 0) begin
               req_valid <= 0;
               while (sb.expected.size() != 0) @(posedge clock);
               @(posedge clock);
            end
         end
         while (plan.size() != 0) send_item(plan.pop_front());
         wait_drained();
      end
      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
